FILE: design/mtg_pkg.sv
package mtg_pkg;

  // generator geometry
  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned ADDR_W        = $clog2(STATE_WORDS);

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] WORDS_USED = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] MID_WRAP   = ADDR_W'(STATE_WORDS - MIDDLE_OFFSET);
  localparam logic [ADDR_W-1:0] MID_STEP   = ADDR_W'(MIDDLE_OFFSET);

  // seeding recurrence
  localparam logic [31:0] SEED_MULT  = 32'd1812433253;
  localparam int unsigned SEED_SHIFT = 30;
  localparam logic [31:0] SEED_RESET = 32'd5489;

  // twist and tempering constants
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam int unsigned TEMPER_U     = 11;
  localparam int unsigned TEMPER_S     = 7;
  localparam int unsigned TEMPER_T     = 15;
  localparam int unsigned TEMPER_L     = 18;

  // request codes
  typedef enum logic [1:0] {
    OP_NEXT   = 2'd0,
    OP_SCALED = 2'd1,
    OP_RESEED = 2'd2
  } op_t;

  // index of the following word, wrapping at the end of the state
  function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] k);
    next_addr = (k == LAST_ADDR) ? '0 : k + ADDR_W'(1);
  endfunction

  // index of the middle word, wrapping at the end of the state
  function automatic logic [ADDR_W-1:0] mid_addr(input logic [ADDR_W-1:0] k);
    mid_addr = (k >= MID_WRAP) ? k - MID_WRAP : k + MID_STEP;
  endfunction

  // output tempering
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> TEMPER_U);
    y = y ^ ((y << TEMPER_S) & TEMPER_B);
    y = y ^ ((y << TEMPER_T) & TEMPER_C);
    y = y ^ (y >> TEMPER_L);
    temper = y;
  endfunction

endpackage

FILE: design/mtg_ram.sv
module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: design/mersenne_twister_generator.sv
// 32-bit MT19937 generator built around a 624-word state memory.
// Requests: pulse start with in_operation and in_bound while busy is low.
//   next (raw word), scaled (also floor(in_bound * word / 2^32)), reseed.
// Configuration: cfg_write_en with cfg_write_data loads the seed register;
//   it takes effect at the next reseed request.
// Results: out_valid is high for one cycle with out_random_word and
//   out_scaled_value; the receiver cannot stall, every result is final.
// Path: a next or scaled request goes through ST_CALC, the twist result
//   stage and the output stage; the first request after reset or reseed
//   goes through ST_LOAD first (the current word is fetched into a register).
// Overlap: busy covers the registered read of the state memory and the
//   write-back of the twisted word; the next request can be taken while the
//   last result is in the output stages; a request twists only the word it consumes.
// Reseed: a pass (one memory write plus a multiply and an add per further
//   word) with busy high, then a result of zeros.
// Reset: the same pass runs with seed 5489 and busy high; it returns no
//   result. Unused request codes return a result of zeros.
module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_bound,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  output logic        out_valid,
  output logic [31:0] out_random_word,
  output logic [31:0] out_scaled_value
);

  localparam int unsigned AW = mtg_pkg::ADDR_W;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_LOAD      = 6'b000010,
    ST_CALC      = 6'b000100,
    ST_SEED_INIT = 6'b001000,
    ST_SEED_MUL  = 6'b010000,
    ST_SEED_ADD  = 6'b100000
  } state_t;

  state_t         state_r, state_nxt;
  logic [31:0]    seed_r;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]  k_r, k_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [31:0]    bound_r, bound_nxt;
  logic [31:0]    cache_r, cache_nxt;
  logic           cache_valid_r, cache_valid_nxt;
  logic [31:0]    prev_r, prev_nxt;
  logic [31:0]    prod_r, prod_nxt;
  logic [AW-1:0]  fill_idx_r, fill_idx_nxt;
  logic           fill_reply_r, fill_reply_nxt;

  // twist result stage
  logic           tw_valid_r, tw_valid_nxt;
  logic [31:0]    tw_word_r, tw_word_nxt;
  logic [31:0]    tw_bound_r, tw_bound_nxt;
  logic           tw_scaled_r, tw_scaled_nxt;

  // output stage
  logic           out_valid_r;
  logic [31:0]    out_word_r;
  logic [31:0]    out_scaled_r;

  // memory ports
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;
  logic [AW-1:0]  rd_addr_a, rd_addr_b;
  logic [31:0]    rd_data_a, rd_data_b;

  logic           accept;
  logic           op_is_next;
  logic [AW-1:0]  k_cur;
  logic [31:0]    twist_y;
  logic [31:0]    twist_word;
  logic [31:0]    seed_mix;
  logic [31:0]    fill_word;
  logic [31:0]    tempered;
  logic [63:0]    scaled_prod;

  mtg_ram #(
    .WIDTH (32),
    .DEPTH (mtg_pkg::STATE_WORDS)
  ) u_state_ram (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // word to consume: a used-up state starts a new round at zero
  assign k_cur = (pos_r == mtg_pkg::WORDS_USED) ? '0 : pos_r;

  assign op_is_next = op_r inside {mtg_pkg::OP_NEXT, mtg_pkg::OP_SCALED};

  // twist of the current word: cache holds word k, port a word k+1, port b the middle word
  assign twist_y    = {cache_r[31], rd_data_a[30:0]};
  assign twist_word = rd_data_b ^ (twist_y >> 1) ^
                      (twist_y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);

  // seeding recurrence, split around the multiplier
  assign seed_mix  = mtg_pkg::SEED_MULT * (prev_r ^ (prev_r >> mtg_pkg::SEED_SHIFT));
  assign fill_word = prod_r + 32'(fill_idx_r);

  // read addresses
  always_comb begin
    rd_addr_a = mtg_pkg::next_addr(k_r);
    rd_addr_b = mtg_pkg::mid_addr(k_r);
    if (state_r == ST_IDLE) begin
      rd_addr_a = cache_valid_r ? mtg_pkg::next_addr(k_cur) : k_cur;
      rd_addr_b = mtg_pkg::mid_addr(k_cur);
    end
  end

  // write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_r;
    mem_wdata = twist_word;
    case (state_r)
      ST_CALC: begin
        mem_we = op_is_next;
      end
      ST_SEED_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = prev_r;
      end
      ST_SEED_ADD: begin
        mem_we    = 1'b1;
        mem_waddr = fill_idx_r;
        mem_wdata = fill_word;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // control sequencer
  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    k_nxt           = k_r;
    op_nxt          = op_r;
    bound_nxt       = bound_r;
    cache_nxt       = cache_r;
    cache_valid_nxt = cache_valid_r;
    prev_nxt        = prev_r;
    prod_nxt        = prod_r;
    fill_idx_nxt    = fill_idx_r;
    fill_reply_nxt  = fill_reply_r;
    tw_valid_nxt    = 1'b0;
    tw_word_nxt     = tw_word_r;
    tw_bound_nxt    = tw_bound_r;
    tw_scaled_nxt   = tw_scaled_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_operation;
          bound_nxt = in_bound;
          k_nxt     = k_cur;
          case (in_operation)
            mtg_pkg::OP_NEXT, mtg_pkg::OP_SCALED: begin
              state_nxt = cache_valid_r ? ST_CALC : ST_LOAD;
            end
            mtg_pkg::OP_RESEED: begin
              prev_nxt       = seed_r;
              fill_reply_nxt = 1'b1;
              state_nxt      = ST_SEED_INIT;
            end
            default: begin
              state_nxt = ST_CALC;
            end
          endcase
        end
      end
      ST_LOAD: begin
        cache_nxt       = rd_data_a;
        cache_valid_nxt = 1'b1;
        state_nxt       = ST_CALC;
      end
      ST_CALC: begin
        tw_valid_nxt  = 1'b1;
        tw_bound_nxt  = bound_r;
        tw_scaled_nxt = (op_r == mtg_pkg::OP_SCALED);
        tw_word_nxt   = op_is_next ? twist_word : 32'd0;
        if (op_is_next) begin
          cache_nxt = rd_data_a;
          pos_nxt   = k_r + AW'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_SEED_INIT: begin
        fill_idx_nxt = AW'(1);
        state_nxt    = ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        prod_nxt  = seed_mix;
        state_nxt = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        prev_nxt = fill_word;
        if (fill_idx_r == mtg_pkg::LAST_ADDR) begin
          pos_nxt         = mtg_pkg::WORDS_USED;
          cache_valid_nxt = 1'b0;
          fill_reply_nxt  = 1'b0;
          tw_valid_nxt    = fill_reply_r;
          tw_word_nxt     = 32'd0;
          tw_scaled_nxt   = 1'b0;
          state_nxt       = ST_IDLE;
        end else begin
          fill_idx_nxt = fill_idx_r + AW'(1);
          state_nxt    = ST_SEED_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SEED_INIT;
      seed_r        <= mtg_pkg::SEED_RESET;
      pos_r         <= mtg_pkg::WORDS_USED;
      cache_valid_r <= 1'b0;
      prev_r        <= mtg_pkg::SEED_RESET;
      fill_idx_r    <= '0;
      fill_reply_r  <= 1'b0;
      tw_valid_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      cache_valid_r <= cache_valid_nxt;
      prev_r        <= prev_nxt;
      fill_idx_r    <= fill_idx_nxt;
      fill_reply_r  <= fill_reply_nxt;
      tw_valid_r    <= tw_valid_nxt;
      if (cfg_write_en) begin
        seed_r <= cfg_write_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    op_r        <= op_nxt;
    bound_r     <= bound_nxt;
    cache_r     <= cache_nxt;
    prod_r      <= prod_nxt;
    tw_word_r   <= tw_word_nxt;
    tw_bound_r  <= tw_bound_nxt;
    tw_scaled_r <= tw_scaled_nxt;
  end

  // tempering and bound scaling into the output registers
  assign tempered    = mtg_pkg::temper(tw_word_r);
  assign scaled_prod = {32'd0, tw_bound_r} * {32'd0, tempered};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tw_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= tempered;
    out_scaled_r <= tw_scaled_r ? scaled_prod[63:32] : 32'd0;
  end

  assign out_valid        = out_valid_r;
  assign out_random_word  = out_word_r;
  assign out_scaled_value = out_scaled_r;

  // a result strobe always comes in the cycle after a twist-stage strobe
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(tw_valid_r))
    else $error("result strobe without a twisted word");

  // consuming a word advances the position past it
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && op_is_next) |=> (pos_r == $past(k_r) + AW'(1)))
    else $error("read position not advanced after twist");

  // the position never runs beyond the used-up mark
  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mtg_pkg::WORDS_USED)
    else $error("read position out of range");

  // a finished seeding pass leaves the state used up and the word cache empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED_ADD && fill_idx_r == mtg_pkg::LAST_ADDR) |=>
      (pos_r == mtg_pkg::WORDS_USED && !cache_valid_r))
    else $error("seeding pass did not mark the state used up");

  // a twist only runs with a valid cached word
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && op_is_next) |-> cache_valid_r)
    else $error("twist without cached current word");

endmodule

FILE: dv/mersenne_twister_generator_tb.sv
module mersenne_twister_generator_tb;

  // independent copy of the generator constants
  localparam int unsigned TWIST_LEN  = 624;
  localparam int unsigned TWIST_MID  = 397;
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] RESET_SEED = 32'd5489;
  localparam logic [31:0] MIX_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] HIGH_MASK  = 32'h8000_0000;
  localparam logic [31:0] LOW_MASK   = 32'h7FFF_FFFF;
  localparam logic [31:0] SHAPE_B    = 32'h9D2C_5680;
  localparam logic [31:0] SHAPE_C    = 32'hEFC6_0000;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          QUIET_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = mtg_pkg::OP_NEXT;
  logic [31:0] in_bound = '0;
  logic        cfg_write_en = 1'b0;
  logic [31:0] cfg_write_data = '0;
  logic        out_valid;
  logic [31:0] out_random_word;
  logic [31:0] out_scaled_value;
  int          quiet_cycles = 0;

  // tracks the generator state and the results still owed by the block
  class twister_scoreboard;
    logic [31:0] words [TWIST_LEN];
    int unsigned position;
    logic [31:0] seed_value;
    logic [31:0] owed_words [$];
    logic [31:0] owed_scaled [$];
    int          error_count;

    function new();
      error_count = 0;
      seed_value  = RESET_SEED;
      fill_from_seed();
    endfunction

    function void report(string msg);
      $display("ERROR: %s", msg);
      error_count++;
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    // seeding recurrence, leaves the state used up
    function void fill_from_seed();
      logic [31:0] prev;
      words[0] = seed_value;
      for (int i = 1; i < TWIST_LEN; i++) begin
        prev = words[i-1];
        words[i] = INIT_MULT * (prev ^ (prev >> 30)) + 32'(i);
      end
      position = TWIST_LEN;
    endfunction

    // regenerate the whole state in place
    function void twist_all();
      logic [31:0] y;
      for (int k = 0; k < TWIST_LEN; k++) begin
        y = (words[k] & HIGH_MASK) | (words[(k + 1) % TWIST_LEN] & LOW_MASK);
        words[k] = words[(k + TWIST_MID) % TWIST_LEN] ^ (y >> 1) ^ (y[0] ? MIX_MATRIX : 32'h0);
      end
      position = 0;
    endfunction

    // next tempered word
    function logic [31:0] draw_word();
      logic [31:0] y;
      if (position >= TWIST_LEN) twist_all();
      y = words[position];
      position++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & SHAPE_B);
      y = y ^ ((y << 15) & SHAPE_C);
      y = y ^ (y >> 18);
      return y;
    endfunction

    // accepted request: work out the result it owes
    function void note_request(logic [1:0] op, logic [31:0] bound);
      logic [31:0] word;
      logic [31:0] scaled;
      logic [63:0] product;
      word   = '0;
      scaled = '0;
      case (op)
        mtg_pkg::OP_NEXT: begin
          word = draw_word();
        end
        mtg_pkg::OP_SCALED: begin
          word    = draw_word();
          product = 64'(bound) * 64'(word);
          scaled  = product[63:32];
        end
        mtg_pkg::OP_RESEED: begin
          fill_from_seed();
        end
        default: begin
        end
      endcase
      owed_words.push_back(word);
      owed_scaled.push_back(scaled);
    endfunction

    // compare a result with the oldest one owed
    function void check_result(logic [31:0] word, logic [31:0] scaled);
      logic [31:0] want_word;
      logic [31:0] want_scaled;
      if (owed_words.size() == 0) begin
        report($sformatf("result %h/%h with no request pending", word, scaled));
        return;
      end
      want_word   = owed_words.pop_front();
      want_scaled = owed_scaled.pop_front();
      if (word !== want_word)
        report($sformatf("random_word got %h want %h", word, want_word));
      if (scaled !== want_scaled)
        report($sformatf("scaled_value got %h want %h", scaled, want_scaled));
    endfunction
  endclass

  twister_scoreboard sb;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mersenne_twister_generator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_bound         (in_bound),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .out_valid        (out_valid),
    .out_random_word  (out_random_word),
    .out_scaled_value (out_scaled_value)
  );

  // monitor: seed writes, results, accepted requests and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_write_en) sb.seed_value = cfg_write_data;
      if (out_valid) sb.check_result(out_random_word, out_scaled_value);
      if (start && !busy) sb.note_request(in_operation, in_bound);
      if (out_valid || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("mersenne_twister_generator: mismatch");
        $finish;
      end
    end
  end

  // present one request and hold it until accepted
  task automatic send_request(input logic [1:0] op, input logic [31:0] bound);
    logic taken;
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_bound     <= bound;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
  endtask

  // sender gap
  task automatic idle_gap(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // stop sending and wait until every owed result has come
  task automatic drain_and_settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  initial begin
    logic [1:0]  op;
    logic [31:0] bound;
    logic [31:0] phase_seed;
    int          phase_len;
    int          pick;

    sb = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    // let the power-on seeding pass finish
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // a seed write alone must not disturb the power-on state
    write_seed(32'h0000_0000);
    send_request(mtg_pkg::OP_NEXT, 32'h0000_0000);
    send_request(mtg_pkg::OP_SCALED, 32'h0000_0000);
    send_request(mtg_pkg::OP_SCALED, 32'hFFFF_FFFF);
    send_request(mtg_pkg::OP_SCALED, 32'h0000_0001);
    send_request(mtg_pkg::OP_SCALED, 32'h8000_0000);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(mtg_pkg::OP_NEXT, 32'hFFFF_FFFF);
    send_request(mtg_pkg::OP_RESEED, 32'h0000_0000);
    send_request(mtg_pkg::OP_NEXT, 32'h0000_0000);
    send_request(mtg_pkg::OP_SCALED, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'h0000_0000);

    // all-ones seed
    drain_and_settle();
    write_seed(32'hFFFF_FFFF);
    send_request(mtg_pkg::OP_RESEED, 32'hFFFF_FFFF);
    send_request(mtg_pkg::OP_NEXT, 32'h0000_0000);
    send_request(mtg_pkg::OP_SCALED, 32'hFFFF_FFFF);
    send_request(mtg_pkg::OP_NEXT, 32'h5555_AAAA);

    // back to the power-on seed
    drain_and_settle();
    write_seed(RESET_SEED);
    send_request(mtg_pkg::OP_RESEED, 32'h0000_0000);
    send_request(mtg_pkg::OP_NEXT, 32'h0000_0000);
    send_request(OP_UNUSED, 32'h1234_5678);
    send_request(mtg_pkg::OP_SCALED, 32'h0000_0010);

    // random phases; the first one runs past a full regeneration
    for (int p = 0; p < 4; p++) begin
      drain_and_settle();
      case (p)
        0: phase_seed = $urandom;
        2: phase_seed = 32'd1;
        default: phase_seed = $urandom;
      endcase
      write_seed(phase_seed);
      phase_len = (p == 0) ? 680 : 140;
      if (p > 0) send_request(mtg_pkg::OP_RESEED, $urandom);
      for (int n = 0; n < phase_len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 46) begin
          op = mtg_pkg::OP_NEXT;
        end else if (pick < 92) begin
          op = mtg_pkg::OP_SCALED;
        end else if (pick < 96 && p > 0) begin
          op = mtg_pkg::OP_RESEED;
        end else if (pick < 96) begin
          op = mtg_pkg::OP_NEXT;
        end else begin
          op = OP_UNUSED;
        end
        case ($urandom_range(0, 5))
          0: bound = 32'h0000_0000;
          1: bound = 32'hFFFF_FFFF;
          2: bound = $urandom_range(1, 16);
          default: bound = $urandom;
        endcase
        send_request(op, bound);
        // bursty sender gaps, with stretches of back-to-back requests
        if (p < 3 && (n / 40) % 3 != 2 && $urandom_range(0, 3) == 0)
          idle_gap($urandom_range(1, 19));
      end
    end

    drain_and_settle();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d requests left without a result", sb.pending()));
    if (sb.error_count == 0) begin
      $display("mersenne_twister_generator: match");
    end else begin
      $display("mersenne_twister_generator: mismatch");
    end
    $finish;
  end

endmodule
